@@ hw/rtl/kmwo_pkg.sv @@
// kmwo_pkg: constants, register map and table builders for the keyed oscillator
// holds the pitch table, the phase increment function and the sine entry function
// no dependencies
package kmwo_pkg;

    localparam int KMWO_PHASE_BITS      = 32;
    localparam int KMWO_SINE_TABLE_BITS = 10;
    localparam int KMWO_SAMPLE_RATE     = 44100;
    localparam int KMWO_NOTE_COUNT      = 16;

    localparam int KMWO_NOTE_W   = 4;
    localparam int KMWO_SAMPLE_W = 16;
    localparam int KMWO_WAVE_W   = 3;
    localparam int KMWO_VOL_W    = 16;
    localparam int KMWO_ADDR_W   = 3;
    localparam int KMWO_DATA_W   = 32;
    localparam int KMWO_LFSR_W   = 16;

    localparam logic [KMWO_LFSR_W-1:0] KMWO_LFSR_TAPS  = 16'hB400;
    localparam logic [KMWO_LFSR_W-1:0] KMWO_LFSR_SEED  = 16'h0001;

    localparam logic [KMWO_WAVE_W-1:0] KMWO_WAVE_RESET = 3'd3;
    localparam logic [KMWO_VOL_W-1:0]  KMWO_VOL_RESET  = 16'd13107;

    // waveform codes
    localparam logic [KMWO_WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [KMWO_WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [KMWO_WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [KMWO_WAVE_W-1:0] WAVE_SAW      = 3'd3;
    localparam logic [KMWO_WAVE_W-1:0] WAVE_NOISE    = 3'd4;

    // register index (word address)
    localparam logic REG_WAVEFORM = 1'b0;
    localparam logic REG_VOLUME   = 1'b1;

    // one octave starting at 110 Hz, Q16.16 Hz
    localparam logic [23:0] OCTAVE_Q16 [12] = '{
        24'd7208960,  24'd7637627,  24'd8091784,  24'd8572947,
        24'd9082720,  24'd9622807,  24'd10195009, 24'd10801236,
        24'd11443511, 24'd12123977, 24'd12844906, 24'd13608704
    };

    // phase increment for note k, rounded half up, by restoring long division
    function automatic logic [63:0] kmwo_step(input int k, input int sample_rate,
                                               input int phase_bits);
        logic [63:0] f;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] sr;
        f  = 64'(OCTAVE_Q16[k % 12]) << (k / 12);
        d  = f << (phase_bits - 16);
        sr = 64'(sample_rate);
        q  = '0;
        r  = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], d[i]};
            q = {q[62:0], 1'b0};
            if (r >= sr) begin
                r    = r - sr;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= sr) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    // quarter-wave polynomial sine, Q15, sign by half period
    function automatic logic signed [15:0] kmwo_sine_entry(input int idx,
                                                           input int table_bits);
        int          qbits;
        int          quad;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        qbits = table_bits - 2;
        quad  = (idx >> qbits) & 3;
        j     = 64'(idx & ((1 << qbits) - 1));
        x     = j << (16 - qbits);
        if ((quad & 1) != 0) begin
            x = 64'd65536 - x;
        end
        x2 = (x * x) >> 16;
        t  = (64'd4640 * x2) >> 16;
        t  = 64'd42047 - t;
        t  = (t * x2) >> 16;
        t  = 64'd102944 - t;
        y  = (t * x) >> 16;
        y  = (y + 64'd1) >> 1;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        return ((quad & 2) != 0) ? -16'(y) : 16'(y);
    endfunction

endpackage

@@ hw/rtl/keyed_multi_waveform_oscillator_top.sv @@
// keyed_multi_waveform_oscillator_top: keyed dds oscillator with five waveforms
// depends on kmwo_pkg for constants, register codes and table builders
//
// One input item is one sample tick; every tick gives one signed Q1.15 sample. Items
// are taken at one per clock while the output is not stalled: the accept edge advances the
// phase accumulator and noise LFSR and reads the sine table into stage one; stage one then
// forms the waveform and applies the master volume multiply into the output register.
// Releasing the key outputs zero and clears the phase. Registers: waveform at byte
// address 0, master_volume at 4; write them only while no item is in flight.
module keyed_multi_waveform_oscillator_top
    import kmwo_pkg::*;
#(
    parameter int PHASE_BITS      = KMWO_PHASE_BITS,
    parameter int SINE_TABLE_BITS = KMWO_SINE_TABLE_BITS,
    parameter int SAMPLE_RATE     = KMWO_SAMPLE_RATE,
    parameter int NOTE_COUNT      = KMWO_NOTE_COUNT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [KMWO_ADDR_W-1:0]          paddr,
    input  logic [KMWO_DATA_W-1:0]          pwdata,
    output logic [KMWO_DATA_W-1:0]          prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [KMWO_NOTE_W-1:0]          s_note_index,
    input  logic                            s_key_pressed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [KMWO_SAMPLE_W-1:0] m_sample
);

    localparam int SINE_DEPTH = 2 ** SINE_TABLE_BITS;
    localparam int NOTE_SLOTS = 2 ** KMWO_NOTE_W;

    // configuration
    logic [KMWO_WAVE_W-1:0] waveform_reg;
    logic [KMWO_VOL_W-1:0]  master_volume_reg;
    logic                   cfg_wr;
    logic                   cfg_idx;

    // front end state
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [KMWO_LFSR_W-1:0] lfsr_reg;
    logic [KMWO_LFSR_W-1:0] lfsr_next;

    // stage one
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            s1_key_reg;
    logic [15:0]                     s1_u_reg;
    logic signed [15:0]              s1_sine_reg;
    logic [KMWO_LFSR_W-1:0]          s1_noise_reg;

    // output stage
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic signed [KMWO_SAMPLE_W-1:0] m_sample_reg;
    logic signed [KMWO_SAMPLE_W-1:0] m_sample_next;

    logic accept;
    logic m_load;
    logic s1_adv;

    logic [PHASE_BITS-1:0]      inc_lut [NOTE_SLOTS];
    logic signed [15:0]         sine_lut [SINE_DEPTH];
    logic [SINE_TABLE_BITS-1:0] sine_idx;

    logic signed [15:0] wave;
    logic signed [18:0] tri_v;
    logic signed [16:0] vol_s;
    logic signed [32:0] prod;

    // constant tables, notes past the last one reuse its pitch
    for (genvar k = 0; k < NOTE_SLOTS; k++) begin : g_inc
        assign inc_lut[k] = PHASE_BITS'(kmwo_step((k < NOTE_COUNT) ? k : NOTE_COUNT - 1,
                                                  SAMPLE_RATE, PHASE_BITS));
    end

    for (genvar i = 0; i < SINE_DEPTH; i++) begin : g_sine
        assign sine_lut[i] = kmwo_sine_entry(i, SINE_TABLE_BITS);
    end

    // apb register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_reg      <= KMWO_WAVE_RESET;
            master_volume_reg <= KMWO_VOL_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WAVEFORM: waveform_reg      <= pwdata[KMWO_WAVE_W-1:0];
                REG_VOLUME:   master_volume_reg <= pwdata[KMWO_VOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WAVEFORM: prdata = KMWO_DATA_W'(waveform_reg);
            REG_VOLUME:   prdata = KMWO_DATA_W'(master_volume_reg);
            default:      prdata = '0;
        endcase
    end

    // handshake
    assign m_load  = !m_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && m_load;
    assign s_ready = !s1_valid_reg || m_load;
    assign accept  = s_valid && s_ready;

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = s1_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // phase and noise advance once per item; a released key clears the phase instead
    always_comb begin
        phase_next = phase_reg;
        lfsr_next  = lfsr_reg;
        if (accept) begin
            phase_next = s_key_pressed ? phase_reg + inc_lut[s_note_index] : '0;
            lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ KMWO_LFSR_TAPS) : (lfsr_reg >> 1);
        end
    end

    assign sine_idx = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            lfsr_reg     <= KMWO_LFSR_SEED;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            lfsr_reg     <= lfsr_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // stage one payload, sampled with the phase in use before the add
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_key_reg   <= s_key_pressed;
            s1_u_reg     <= phase_reg[PHASE_BITS-1 -: 16];
            s1_sine_reg  <= sine_lut[sine_idx];
            s1_noise_reg <= lfsr_reg;
        end
    end

    // waveform select
    always_comb begin
        if (s1_u_reg < 16'd16384) begin
            tri_v = 19'sd2 * $signed({3'b000, s1_u_reg});
        end else if (s1_u_reg < 16'd49152) begin
            tri_v = 19'sd65536 - 19'sd2 * $signed({3'b000, s1_u_reg});
        end else begin
            tri_v = 19'sd2 * $signed({3'b000, s1_u_reg}) - 19'sd131072;
        end
    end

    always_comb begin
        case (waveform_reg)
            WAVE_SINE:     wave = s1_sine_reg;
            WAVE_SQUARE:   wave = (s1_sine_reg > 16'sd0) ? 16'sh7FFF : 16'sh8000;
            WAVE_TRIANGLE: begin
                if (tri_v > 19'sd32767) begin
                    wave = 16'sh7FFF;
                end else if (tri_v < -19'sd32768) begin
                    wave = 16'sh8000;
                end else begin
                    wave = tri_v[15:0];
                end
            end
            WAVE_SAW:      wave = $signed(s1_u_reg ^ 16'h8000);
            WAVE_NOISE:    wave = $signed(s1_noise_reg ^ 16'h8000);
            default:       wave = '0;
        endcase
    end

    // volume gain, arithmetic shift gives the floor
    assign vol_s = $signed({1'b0, master_volume_reg});
    assign prod  = wave * vol_s;

    assign m_sample_next = s1_key_reg ? prod[31:16] : '0;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_sample_reg <= m_sample_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // released key clears the accumulator
    a_phase_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_key_pressed |=> phase_reg == '0)
        else $error("phase not cleared on key release");

    // released key gives a silent sample
    a_key_silence: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && !s1_key_reg |=> m_sample_reg == '0)
        else $error("nonzero sample with key released");

    // codes above noise are silent
    a_code_silence: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && waveform_reg > WAVE_NOISE |=> m_sample_reg == '0)
        else $error("nonzero sample for silence code");

    // galois lfsr never locks up at zero
    a_lfsr_live: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("noise register reached zero");

    // no item taken while both stages are full and output stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken with pipeline full");

endmodule

@@ test/tb_keyed_multi_waveform_oscillator_top.sv @@
// tb_keyed_multi_waveform_oscillator_top: self-checking testbench for the keyed dds oscillator
// predicts every sample in the testbench and compares it with the block's output
// depends on kmwo_pkg and keyed_multi_waveform_oscillator_top
`timescale 1ns / 100ps

module tb_keyed_multi_waveform_oscillator_top;
    import kmwo_pkg::*;

    localparam int PHASE_W   = KMWO_PHASE_BITS;
    localparam int SINE_BITS = KMWO_SINE_TABLE_BITS;
    localparam longint RATE  = KMWO_SAMPLE_RATE;

    typedef struct packed {
        logic [KMWO_NOTE_W-1:0] note;
        logic                   key;
    } tick_t;

    // A2 octave in Q16.16 Hz
    localparam longint PITCH_Q16 [12] = '{
        7208960, 7637627, 8091784, 8572947, 9082720, 9622807,
        10195009, 10801236, 11443511, 12123977, 12844906, 13608704
    };

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [KMWO_ADDR_W-1:0]          paddr         = '0;
    logic [KMWO_DATA_W-1:0]          pwdata        = '0;
    logic [KMWO_DATA_W-1:0]          prdata;
    logic                            pready;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [KMWO_NOTE_W-1:0]          s_note_index  = '0;
    logic                            s_key_pressed = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic signed [KMWO_SAMPLE_W-1:0] m_sample;

    // oscillator state as the testbench sees it
    logic [PHASE_W-1:0]     osc_phase  = '0;
    logic [KMWO_LFSR_W-1:0] noise_lfsr = KMWO_LFSR_SEED;
    logic [KMWO_WAVE_W-1:0] cfg_wave   = KMWO_WAVE_RESET;
    logic [KMWO_VOL_W-1:0]  cfg_volume = KMWO_VOL_RESET;

    tick_t                           tick_q[$];
    logic signed [KMWO_SAMPLE_W-1:0] sample_q[$];

    int   gap_left       = 0;
    int   stall_left     = 0;
    int   gap_pct        = 0;
    int   stall_pct      = 0;
    int   ticks_accepted = 0;
    int   fail_count     = 0;
    logic hold_off       = 1'b0;

    keyed_multi_waveform_oscillator_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_note_index  (s_note_index),
        .s_key_pressed (s_key_pressed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // phase increment for a note, rounded half up
    function automatic logic [PHASE_W-1:0] note_increment(input logic [KMWO_NOTE_W-1:0] note);
        longint unsigned freq;
        longint unsigned quo;
        longint unsigned rem;
        int              n;
        n    = (int'(note) >= KMWO_NOTE_COUNT) ? KMWO_NOTE_COUNT - 1 : int'(note);
        freq = longint'(PITCH_Q16[n % 12]) << (n / 12);
        quo  = freq / RATE;
        rem  = freq % RATE;
        repeat (PHASE_W - 16) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= RATE) begin
                quo = quo | 1;
                rem = rem - RATE;
            end
        end
        if (2 * rem >= RATE) begin
            quo = quo + 1;
        end
        return quo[PHASE_W-1:0];
    endfunction

    // quarter-wave polynomial, mirrored on odd quadrants, negated in the second half
    function automatic logic signed [15:0] sine_q15(input logic [SINE_BITS-1:0] idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] poly;
        logic [63:0] y;
        x = 64'(idx[SINE_BITS-3:0]) << (18 - SINE_BITS);
        if (idx[SINE_BITS-2]) begin
            x = 64'd65536 - x;
        end
        x2   = (x * x) >> 16;
        poly = 64'd42047 - ((64'd4640 * x2) >> 16);
        poly = 64'd102944 - ((poly * x2) >> 16);
        y    = ((poly * x) >> 16) + 64'd1;
        y    = y >> 1;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        return idx[SINE_BITS-1] ? -16'(y) : 16'(y);
    endfunction

    task automatic synth_tick(input tick_t t);
        logic [KMWO_LFSR_W-1:0]          noise_now;
        logic signed [KMWO_SAMPLE_W-1:0] result;
        int                              u;
        int                              wave;
        longint                          prod;
        noise_now  = noise_lfsr;
        noise_lfsr = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ KMWO_LFSR_TAPS) : (noise_lfsr >> 1);
        if (!t.key) begin
            osc_phase = '0;
            result    = '0;
        end else begin
            u = int'(osc_phase[PHASE_W-1 -: 16]);
            case (cfg_wave)
                WAVE_SINE: wave = sine_q15(osc_phase[PHASE_W-1 -: SINE_BITS]);
                WAVE_SQUARE: wave = (sine_q15(osc_phase[PHASE_W-1 -: SINE_BITS]) > 0) ?
                                    32767 : -32768;
                WAVE_TRIANGLE: begin
                    if (u < 16384) begin
                        wave = 2 * u;
                    end else if (u < 49152) begin
                        wave = 65536 - 2 * u;
                    end else begin
                        wave = 2 * u - 131072;
                    end
                    if (wave > 32767) begin
                        wave = 32767;
                    end
                    if (wave < -32768) begin
                        wave = -32768;
                    end
                end
                WAVE_SAW:   wave = u - 32768;
                WAVE_NOISE: wave = int'(noise_now) - 32768;
                default:    wave = 0;
            endcase
            osc_phase = osc_phase + note_increment(t.note);
            prod      = longint'(wave) * longint'(cfg_volume);
            // arithmetic shift floors toward minus infinity
            result    = 16'(prod >>> 16);
        end
        sample_q.push_back(result);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // input side: items go out of tick_q, idle bursts in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_note_index  <= '0;
            s_key_pressed <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                synth_tick('{note: s_note_index, key: s_key_pressed});
                ticks_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left == 0 && tick_q.size() != 0 && gap_pct != 0 &&
                    $urandom_range(99, 0) < gap_pct) begin
                    gap_left = $urandom_range(19, 1);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    tick_t t;
                    t = tick_q.pop_front();
                    s_valid       <= 1'b1;
                    s_note_index  <= t.note;
                    s_key_pressed <= t.key;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each sample with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    note_failure($sformatf("unexpected sample %0d", m_sample));
                end else begin
                    logic signed [KMWO_SAMPLE_W-1:0] want;
                    want = sample_q.pop_front();
                    if (m_sample !== want) begin
                        note_failure($sformatf("sample mismatch: expected %0d, got %0d",
                                               want, m_sample));
                    end
                end
            end
            if (stall_left == 0 && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
                stall_left = $urandom_range(19, 1);
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off while the sender keeps going, so the block backs up
    initial begin
        wait (ticks_accepted >= 150 && tick_q.size() >= 20);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (150) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic reg_write(input logic index, input logic [KMWO_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KMWO_ADDR_W'({index, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_WAVEFORM) begin
            cfg_wave = data[KMWO_WAVE_W-1:0];
        end else begin
            cfg_volume = data[KMWO_VOL_W-1:0];
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (tick_q.size() != 0 || s_valid || sample_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // mostly held notes of random length, each ended by a release; some loose random items
    task automatic queue_phrases(input int count);
        int    added;
        int    run;
        tick_t t;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99, 0) < 15) begin
                t.note = KMWO_NOTE_W'($urandom());
                t.key  = 1'($urandom());
                tick_q.push_back(t);
                added++;
            end else begin
                run    = $urandom_range(80, 1);
                t.note = KMWO_NOTE_W'($urandom());
                t.key  = 1'b1;
                repeat (run) begin
                    if ($urandom_range(99, 0) < 10) begin
                        t.note = KMWO_NOTE_W'($urandom());
                    end
                    tick_q.push_back(t);
                end
                t.key = 1'b0;
                repeat ($urandom_range(3, 1)) begin
                    t.note = KMWO_NOTE_W'($urandom());
                    tick_q.push_back(t);
                end
                added += run;
            end
        end
    endtask

    initial begin
        logic [KMWO_VOL_W-1:0] vol_pick [8];
        vol_pick = '{16'd65535, 16'd32768, KMWO_VOL_RESET, 16'd1,
                     16'($urandom()), 16'd0, 16'd65535, 16'($urandom())};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: every waveform code at full scale (code 5 at zero volume), top and bottom note, release
        for (int w = 0; w < 8; w++) begin
            reg_write(REG_WAVEFORM, {29'($urandom()), 3'(w)});
            reg_write(REG_VOLUME, {16'($urandom()), (w == 5) ? 16'd0 : 16'd65535});
            tick_q.push_back('{note: 4'd15, key: 1'b1});
            tick_q.push_back('{note: 4'd0, key: 1'b1});
            tick_q.push_back('{note: 4'(2 * w + 1), key: 1'b0});
            wait_idle();
        end

        // random phrases under each setting; settings 3 and 7 run with no random gaps or stalls
        for (int p = 0; p < 8; p++) begin
            reg_write(REG_WAVEFORM, {29'($urandom()), 3'(p)});
            reg_write(REG_VOLUME, {16'($urandom()), vol_pick[p]});
            if (p == 3 || p == 7) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(30, 5);
                stall_pct = $urandom_range(30, 5);
            end
            queue_phrases(60);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
